// ----- rtl/imc_pkg.sv -----
// Shared types, constants and mod-97 arithmetic for the IBAN check block.
package imc_pkg;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    localparam logic [5:0] LETTER_BASE = 6'd10;

    // Arithmetic constants
    localparam logic [8:0] MOD_BASE   = 9'd97;
    localparam logic [5:0] COUNT_SAT  = 6'd63;
    localparam logic [5:0] PREFIX_LEN = 6'd4;
    localparam logic [5:0] LETTER_POS = 6'd2;

    // Token queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Config register indexes
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_CHAR   = 3'd1,
        ST_BAD_PREFIX = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_BAD_SUM    = 3'd4
    } t_status;

    // One classified character
    typedef struct packed {
        logic [5:0] value;   // 0..9 digit, 10..35 letter, 0 otherwise
        logic       digit;
        logic       alnum;
        logic       space;
        logic       last;
    } t_token;

    // Running totals handed from the back end to the finishing stages
    typedef struct packed {
        logic [6:0] run;     // remainder of the body after the prefix
        logic [6:0] mult;    // 10^k mod 97, k = decimal digits of the prefix
        logic [6:0] pre;     // remainder of the prefix alone
        logic [5:0] count;
        t_status    err;
    } t_fin;

    // x mod 97 for x < 2^14; 128 mod 97 = 31, so fold the high bits down
    function automatic logic [6:0] mod97(input logic [13:0] x);
        logic [11:0] y;
        logic [10:0] z;
        logic [8:0]  w;
        logic [8:0]  r;
        y = 12'({x[13:7], 5'b0}) - 12'(x[13:7]) + 12'(x[6:0]);
        z = 11'({y[11:7], 5'b0}) - 11'(y[11:7]) + 11'(y[6:0]);
        w = 9'({z[10:7], 5'b0}) - 9'(z[10:7]) + 9'(z[6:0]);
        priority if (w >= 9'(3 * MOD_BASE)) r = w - 9'(3 * MOD_BASE);
        else if (w >= 9'(2 * MOD_BASE))     r = w - 9'(2 * MOD_BASE);
        else if (w >= MOD_BASE)             r = w - MOD_BASE;
        else                                r = w;
        return r[6:0];
    endfunction

    // Append one mapped character: digits shift by 10, letters by 100
    function automatic logic [6:0] fold(input logic [6:0] r, input logic [5:0] v);
        logic [13:0] x;
        if (v < LETTER_BASE) x = 14'(r) * 14'd10 + 14'(v);
        else                 x = 14'(r) * 14'd100 + 14'(v);
        return mod97(x);
    endfunction

    // Scale factor update matching fold() for the same character
    function automatic logic [6:0] scale(input logic [6:0] m, input logic [5:0] v);
        logic [13:0] x;
        if (v < LETTER_BASE) x = 14'(m) * 14'd10;
        else                 x = 14'(m) * 14'd100;
        return mod97(x);
    endfunction

endpackage

// ----- rtl/imc_front.sv -----
// Front end: accepts characters, folds case and classifies them into tokens.
module imc_front (
    input  logic               i_in_valid,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    input  logic               i_q_full,
    output logic               o_in_ready,
    output logic               o_push,
    output imc_pkg::t_token    o_tok
);

    logic [7:0] uc;
    logic       is_digit;
    logic       is_letter;

    // Case fold and character class
    always_comb begin
        if (i_char_code >= imc_pkg::CHAR_LA && i_char_code <= imc_pkg::CHAR_LZ) begin
            uc = i_char_code - imc_pkg::CASE_DIFF;
        end else begin
            uc = i_char_code;
        end
        is_digit  = (uc >= imc_pkg::CHAR_0) && (uc <= imc_pkg::CHAR_9);
        is_letter = (uc >= imc_pkg::CHAR_UA) && (uc <= imc_pkg::CHAR_UZ);
    end

    // Token build
    always_comb begin
        o_tok.digit = is_digit;
        o_tok.alnum = is_digit || is_letter;
        o_tok.space = (i_char_code == imc_pkg::CHAR_SPACE);
        o_tok.last  = i_last_char;
        if (is_digit) begin
            o_tok.value = 6'(uc - imc_pkg::CHAR_0);
        end else if (is_letter) begin
            o_tok.value = 6'(uc - imc_pkg::CHAR_UA) + imc_pkg::LETTER_BASE;
        end else begin
            o_tok.value = '0;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

// ----- rtl/imc_queue.sv -----
// Short token queue between the front end and the back end.
module imc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  imc_pkg::t_token    i_tok,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_head_valid,
    output imc_pkg::t_token    o_head
);

    imc_pkg::t_token                 r_mem [imc_pkg::QDEPTH];
    logic [imc_pkg::QPTR_W-1:0]      r_wr;
    logic [imc_pkg::QPTR_W-1:0]      r_rd;
    logic [imc_pkg::QCNT_W-1:0]      r_cnt;
    logic [imc_pkg::QPTR_W-1:0]      n_wr;
    logic [imc_pkg::QPTR_W-1:0]      n_rd;
    logic [imc_pkg::QCNT_W-1:0]      n_cnt;

    // Pointer and fill update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == imc_pkg::QPTR_W'(imc_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == imc_pkg::QPTR_W'(imc_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    assign o_full       = (r_cnt == imc_pkg::QCNT_W'(imc_pkg::QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= imc_pkg::QCNT_W'(imc_pkg::QDEPTH))
        else $error("queue fill above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("push lost");

endmodule

// ----- rtl/imc_back.sv -----
// Back end: per-character state update, prefix capture and running remainder.
module imc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  imc_pkg::t_token    i_head,
    input  logic               i_fin_ready,
    output logic               o_pop,
    output logic               o_fin_valid,
    output imc_pkg::t_fin      o_fin
);

    logic [6:0]        r_run;
    logic [6:0]        r_mult;
    logic [6:0]        r_pre;
    logic [5:0]        r_count;
    imc_pkg::t_status  r_err;
    logic [6:0]        n_run;
    logic [6:0]        n_mult;
    logic [6:0]        n_pre;
    logic [5:0]        n_count;
    imc_pkg::t_status  n_err;
    logic [5:0]        pv;

    // A final character waits until the finishing stage has room
    assign o_pop       = i_head_valid && (!i_head.last || i_fin_ready);
    assign o_fin_valid = o_pop && i_head.last;

    // Next state including the character at the head
    always_comb begin
        n_run   = r_run;
        n_mult  = r_mult;
        n_pre   = r_pre;
        n_count = r_count;
        n_err   = r_err;
        pv      = i_head.alnum ? i_head.value : '0;
        if (o_pop && !i_head.space) begin
            // prefix slots fold in order; a bad character holds zero
            if (r_count < imc_pkg::PREFIX_LEN) begin
                n_pre  = imc_pkg::fold(r_pre, pv);
                n_mult = imc_pkg::scale(r_mult, pv);
            end else if (i_head.alnum) begin
                n_run = imc_pkg::fold(r_run, i_head.value);
            end
            if (r_err == imc_pkg::ST_OK) begin
                if (!i_head.alnum) begin
                    n_err = imc_pkg::ST_BAD_CHAR;
                end else if (r_count < imc_pkg::PREFIX_LEN &&
                             ((r_count < imc_pkg::LETTER_POS) == i_head.digit)) begin
                    n_err = imc_pkg::ST_BAD_PREFIX;
                end
            end
            if (r_count != imc_pkg::COUNT_SAT) begin
                n_count = r_count + 1'b1;
            end
        end
        o_fin.run   = n_run;
        o_fin.mult  = n_mult;
        o_fin.pre   = n_pre;
        o_fin.count = n_count;
        o_fin.err   = n_err;
    end

    // State registers; cleared after each final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_fin_valid) begin
            r_run   <= '0;
            r_mult  <= 7'd1;
            r_pre   <= '0;
            r_count <= '0;
            r_err   <= imc_pkg::ST_OK;
        end else begin
            r_run   <= n_run;
            r_mult  <= n_mult;
            r_pre   <= n_pre;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    a_fin_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fin_valid |-> i_fin_ready && i_head.last)
        else $error("result handed over without room");
    a_mult_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mult != '0 && r_mult < 7'(imc_pkg::MOD_BASE))
        else $error("prefix scale out of range");

endmodule

// ----- rtl/imc_tail.sv -----
// Finishing stages: prefix rotation, length and status checks, output register.
module imc_tail #(
    parameter int MAX_IBAN_CHARS = 34
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fin_valid,
    input  imc_pkg::t_fin      i_fin,
    input  logic [5:0]         i_min_len,
    input  logic [5:0]         i_max_len,
    input  logic               i_out_ready,
    output logic               o_fin_ready,
    output logic               o_out_valid,
    output logic               o_valid_res,
    output logic [2:0]         o_status,
    output logic [6:0]         o_remainder
);

    localparam logic [5:0] MAX_CHARS = 6'(MAX_IBAN_CHARS);

    logic              r_s1_valid;
    logic [13:0]       r_prod;
    logic [6:0]        r_pre;
    logic [5:0]        r_count;
    imc_pkg::t_status  r_err;
    logic              r_out_valid;
    logic              r_valid_res;
    imc_pkg::t_status  r_status;
    logic [6:0]        r_rem;
    logic              out_load;
    logic [6:0]        n_rem;
    logic              len_bad;
    imc_pkg::t_status  n_status;

    assign out_load    = !r_out_valid || i_out_ready;
    assign o_fin_ready = !r_s1_valid || out_load;

    // Stage 1: body remainder times 10^k, registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_s1_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin_valid) begin
            r_prod  <= 14'(i_fin.run) * 14'(i_fin.mult);
            r_pre   <= i_fin.pre;
            r_count <= i_fin.count;
            r_err   <= i_fin.err;
        end
    end

    // Stage 2: final remainder and status priority
    always_comb begin
        n_rem   = imc_pkg::mod97(r_prod + 14'(r_pre));
        len_bad = (r_count < i_min_len) || (r_count > i_max_len) ||
                  (r_count > MAX_CHARS) || (r_count == imc_pkg::COUNT_SAT);
        priority if (r_err != imc_pkg::ST_OK)     n_status = r_err;
        else if (len_bad)                         n_status = imc_pkg::ST_BAD_LENGTH;
        else if (r_count < imc_pkg::PREFIX_LEN)   n_status = imc_pkg::ST_BAD_PREFIX;
        else if (n_rem != 7'd1)                   n_status = imc_pkg::ST_BAD_SUM;
        else                                      n_status = imc_pkg::ST_OK;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_valid_res <= (n_status == imc_pkg::ST_OK);
            r_status    <= n_status;
            r_rem       <= n_rem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_valid_res;
    assign o_status    = r_status;
    assign o_remainder = r_rem;

    a_res_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_valid_res == (o_status == 3'(imc_pkg::ST_OK)))
        else $error("valid flag disagrees with status");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_remainder < 7'(imc_pkg::MOD_BASE))
        else $error("remainder not reduced");

endmodule

// ----- rtl/iban_mod97_check_top.sv -----
// IBAN mod-97 checker top level: config registers and front/queue/back/tail.
// Takes one IBAN character per item at up to one item per clock; spaces are
// skipped, lowercase folds to uppercase, and the item flagged last produces one
// result (valid flag, status, remainder), passing through the queue, the stage-1
// register and the output register. The rate is set by the back end, which folds
// one character into the running remainder with a combinational mod-97 reduction;
// the prefix is rotated to the end with one 7x7 multiply in the finishing stage.
// A four-entry token queue and the output register let input and output stall
// independently. Config registers (index 0 min length, 1 max length) should be
// written only while no IBAN is in flight; the port is always ready.
module iban_mod97_check_top #(
    parameter int MAX_IBAN_CHARS = 34
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_valid_res,
    output logic [2:0]  o_status,
    output logic [6:0]  o_remainder,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    logic [5:0]       r_min_len;
    logic [5:0]       r_max_len;
    logic             q_full;
    logic             push;
    imc_pkg::t_token  tok;
    logic             pop;
    logic             head_valid;
    imc_pkg::t_token  head;
    logic             fin_ready;
    logic             fin_valid;
    imc_pkg::t_fin    fin;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= 6'd15;
            r_max_len <= 6'd34;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                imc_pkg::CFG_MIN_LEN: r_min_len <= i_cfg_data;
                imc_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_data;
                default:              r_min_len <= r_min_len;
            endcase
        end
    end

    imc_front u_front (
        .i_in_valid  (i_in_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_q_full    (q_full),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_tok       (tok)
    );

    imc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_tok        (tok),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    imc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_fin_ready  (fin_ready),
        .o_pop        (pop),
        .o_fin_valid  (fin_valid),
        .o_fin        (fin)
    );

    imc_tail #(
        .MAX_IBAN_CHARS (MAX_IBAN_CHARS)
    ) u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .i_min_len   (r_min_len),
        .i_max_len   (r_max_len),
        .i_out_ready (i_out_ready),
        .o_fin_ready (fin_ready),
        .o_out_valid (o_out_valid),
        .o_valid_res (o_valid_res),
        .o_status    (o_status),
        .o_remainder (o_remainder)
    );

endmodule

// ----- verif/iban_mod97_check_top_test.sv -----
// Self-checking testbench for the IBAN mod-97 checker: directed table plus random texts.
`timescale 1ns / 100ps

module iban_mod97_check_top_test;
    import imc_pkg::*;

    localparam int IBAN_MAX      = 34;
    localparam int RAND_CHARS    = 700;
    localparam int PHASE_CHARS   = 80;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int unsigned NOT_ALNUM = 99;
    localparam int DIR_ROWS      = 8;

    // One result: pass flag, status code, final remainder
    typedef struct packed {
        logic       ok;
        t_status    st;
        logic [6:0] rem;
    } verdict_t;

    // Directed row: text right-justified in txt, n bytes; lo of zero keeps the bounds
    typedef struct packed {
        logic [63:0] txt;
        logic [3:0]  n;
        logic [5:0]  lo;
        logic [5:0]  hi;
        logic        pin;
        verdict_t    want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // lone space, empty once spaces are skipped, at reset bounds
        '{" ",      4'd1, 6'd0, 6'd0, 1'b1, '{1'b0, ST_BAD_LENGTH, 7'd0}},
        // lowest and highest byte: bad character wins over bad length
        '{64'h00,   4'd1, 6'd0, 6'd0, 1'b1, '{1'b0, ST_BAD_CHAR, 7'd0}},
        '{64'hFF,   4'd1, 6'd0, 6'd0, 1'b1, '{1'b0, ST_BAD_CHAR, 7'd0}},
        // digit where a letter belongs, lowercase letter
        '{"1z",     4'd2, 6'd0, 6'd0, 1'b0, '{1'b0, ST_OK, 7'd0}},
        // shortest legal IBAN, then lowercase with an inner space
        '{"AA750",  4'd5, 6'd5, 6'd5, 1'b1, '{1'b1, ST_OK, 7'd1}},
        '{"aa75 0", 4'd6, 6'd0, 6'd0, 1'b1, '{1'b1, ST_OK, 7'd1}},
        // checksum mismatch
        '{"AA751",  4'd5, 6'd0, 6'd0, 1'b0, '{1'b0, ST_OK, 7'd0}},
        // min above max, last item is a space
        '{"AA750 ", 4'd6, 6'd6, 6'd5, 1'b1, '{1'b0, ST_BAD_LENGTH, 7'd1}}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_char_code;
    logic       i_last_char;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_valid_res;
    logic [2:0] o_status;
    logic [6:0] o_remainder;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [5:0] i_cfg_data;

    iban_mod97_check_top #(
        .MAX_IBAN_CHARS(IBAN_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_valid_res (o_valid_res),
        .o_status    (o_status),
        .o_remainder (o_remainder),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Checker state: bounds, held prefix values, body remainder, count, first fault
    int unsigned len_lo;
    int unsigned len_hi;
    int unsigned head_val [4];
    int unsigned body_rem;
    int unsigned seen;
    t_status     first_fault;

    verdict_t    verdicts_due [$];
    verdict_t    due;
    logic [7:0]  text_buf [$];
    int          n_miss;
    int          chars_sent;
    int          cycle_count;
    bit          in_calm;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Append one mapped character to a remainder: digits shift by 10, letters by 100
    function automatic int unsigned mod_append(input int unsigned r, input int unsigned v);
        if (v < LETTER_BASE) return (r * 10 + v) % MOD_BASE;
        return (r * 100 + v) % MOD_BASE;
    endfunction

    // 0..9 for digits, 10..35 for letters of either case, NOT_ALNUM otherwise
    function automatic int unsigned code_val(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= CHAR_LA && c <= CHAR_LZ) c = c - CASE_DIFF;
        if (c >= CHAR_0 && c <= CHAR_9) return c - CHAR_0;
        if (c >= CHAR_UA && c <= CHAR_UZ) return c - CHAR_UA + LETTER_BASE;
        return NOT_ALNUM;
    endfunction

    function automatic void clear_checker();
        int k;
        for (k = 0; k < 4; k++) head_val[k] = 0;
        body_rem = 0;
        seen = 0;
        first_fault = ST_OK;
    endfunction

    // Fold one accepted item into the checker; returns 1 with the verdict on the last item
    function automatic bit iban_take_char(input logic [7:0] code, input logic fin,
                                          output verdict_t v);
        int unsigned val;
        int unsigned r;
        int unsigned n;
        int          k;
        t_status     st;
        v = '0;
        if (code != CHAR_SPACE) begin
            val = code_val(code);
            if (val == NOT_ALNUM) begin
                if (first_fault == ST_OK) first_fault = ST_BAD_CHAR;
            end else if (seen < 4) begin
                head_val[seen] = val;
                if ((seen < 2) == (val < LETTER_BASE) && first_fault == ST_OK)
                    first_fault = ST_BAD_PREFIX;
            end else begin
                body_rem = mod_append(body_rem, val);
            end
            if (seen < COUNT_SAT) seen++;
        end
        if (!fin) return 1'b0;

        // rotate the held prefix to the end
        r = body_rem;
        n = (seen < 4) ? seen : 4;
        for (k = 0; k < n; k++) r = mod_append(r, head_val[k]);

        if (first_fault != ST_OK)
            st = first_fault;
        else if (seen < len_lo || seen > len_hi || seen > IBAN_MAX || seen >= COUNT_SAT)
            st = ST_BAD_LENGTH;
        else if (seen < 4)
            st = ST_BAD_PREFIX;
        else if (r != 1)
            st = ST_BAD_SUM;
        else
            st = ST_OK;
        v.ok  = (st == ST_OK);
        v.st  = st;
        v.rem = r[6:0];
        clear_checker();
        return 1'b1;
    endfunction

    task automatic report_miss(input string what, input int got, input int want);
        n_miss++;
        $display("mismatch on %s: got %0d, want %0d (at %0t)", what, got, want, $time);
    endtask

    // Drive one item after a random gap and wait for it to be taken
    task automatic send_char(input logic [7:0] code, input logic fin, input bit pin,
                             input verdict_t pinned);
        int       gap;
        verdict_t v;
        gap = in_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= code;
        i_last_char <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
        if (iban_take_char(code, fin, v)) verdicts_due.push_back(pin ? pinned : v);
    endtask

    // Send text_buf, optionally grouped by four with spaces and closed by a space
    task automatic send_text(input bit grouped, input bit tail_space, input bit pin,
                             input verdict_t pinned);
        int k;
        bit fin;
        for (k = 0; k < text_buf.size(); k++) begin
            fin = (k == text_buf.size() - 1) && !tail_space;
            send_char(text_buf[k], fin, pin, pinned);
            if (grouped && (k % 4 == 3) && !fin) send_char(CHAR_SPACE, 1'b0, pin, pinned);
        end
        if (tail_space) send_char(CHAR_SPACE, 1'b1, pin, pinned);
        if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
    endtask

    // Idle the input and let every pending result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both length bounds, back to back
    task automatic set_lengths(input logic [5:0] lo, input logic [5:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MIN_LEN;
        i_cfg_data  <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_MAX_LEN;
        i_cfg_data  <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_lo = lo;
        len_hi = hi;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = CHAR_UA + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1) c = c + CASE_DIFF;
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CHAR_0 + 8'($urandom_range(0, 9));
    endfunction

    // Letter-letter-digit-digit prefix and alphanumeric body; check digits right or random
    task automatic build_iban(input bit good_sum, input bit broken);
        int unsigned n;
        int unsigned r;
        int unsigned cd;
        int unsigned k;
        int unsigned pos;
        logic [7:0]  l1;
        logic [7:0]  l2;
        logic [7:0]  c;
        logic [7:0]  body [$];
        if (len_lo <= len_hi) n = $urandom_range(len_lo, len_hi);
        else n = $urandom_range(5, IBAN_MAX);
        case ($urandom_range(0, 19))
            0: n = len_lo - 1;
            1: n = len_hi + 1;
            2: n = $urandom_range(60, 68);
            default: ;
        endcase
        if (n < 4) n = 4;

        l1 = rand_letter();
        l2 = rand_letter();
        r = 0;
        for (k = 4; k < n; k++) begin
            c = ($urandom_range(0, 2) == 0) ? rand_letter() : rand_digit();
            body.push_back(c);
            r = mod_append(r, code_val(c));
        end
        // check digits of zero give the remainder to correct
        r = mod_append(mod_append(r, code_val(l1)), code_val(l2));
        r = mod_append(mod_append(r, 0), 0);
        cd = good_sum ? 98 - r : $urandom_range(0, 99);

        text_buf = {};
        text_buf.push_back(l1);
        text_buf.push_back(l2);
        text_buf.push_back(CHAR_0 + 8'(cd / 10));
        text_buf.push_back(CHAR_0 + 8'(cd % 10));
        foreach (body[k2]) text_buf.push_back(body[k2]);

        // corrupt one byte, or put the wrong class into the prefix
        if (broken) begin
            if ($urandom_range(0, 1) == 0) begin
                pos = $urandom_range(0, n - 1);
                text_buf[pos] = 8'($urandom_range(0, 255));
            end else begin
                pos = $urandom_range(0, 3);
                text_buf[pos] = (pos < 2) ? rand_digit() : rand_letter();
            end
        end
    endtask

    // Random bytes, now and then long enough to saturate the count
    task automatic build_noise();
        int unsigned n;
        int unsigned k;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 30);
        text_buf = {};
        for (k = 0; k < n; k++) text_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Result side: check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                report_miss("unexpected result", o_status, -1);
            end else begin
                due = verdicts_due.pop_front();
                if (o_valid_res !== due.ok) report_miss("valid_res", o_valid_res, due.ok);
                if (o_status !== due.st) report_miss("status", o_status, due.st);
                if (o_remainder !== due.rem) report_miss("remainder", o_remainder, due.rem);
            end
        end
    end

    // Result side: random stall before each result, with calm stretches
    initial begin
        int stall;
        bit out_calm;
        out_calm = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            stall = out_calm ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if ($urandom_range(0, 9) == 0) out_calm = !out_calm;
        end
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("iban_mod97_check_top regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int        r;
        int        k;
        int        phase;
        int        mark;
        int        pick;
        dir_row_t  row;
        logic [5:0] lo;
        logic [5:0] hi;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_code = '0;
        i_last_char = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIN_LEN;
        i_cfg_data  = '0;
        chars_sent  = 0;
        in_calm     = 1'b0;
        len_lo      = 15;
        len_hi      = 34;
        clear_checker();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.lo != 0) begin
                settle();
                set_lengths(row.lo, row.hi);
            end
            text_buf = {};
            for (k = 0; k < row.n; k++) text_buf.push_back(row.txt[8 * (row.n - 1 - k) +: 8]);
            send_text(1'b0, 1'b0, row.pin, row.want);
        end

        // random phases: extremes of the bounds first, then a fixed middle range, then random bounds
        chars_sent = 0;
        for (phase = 0; chars_sent < RAND_CHARS; phase++) begin
            case (phase)
                0: begin lo = 6'd5;  hi = 6'd5;  end
                1: begin lo = 6'd34; hi = 6'd34; end
                2: begin lo = 6'd34; hi = 6'd5;  end
                3: begin lo = 6'd5;  hi = 6'd34; end
                4: begin lo = 6'd16; hi = 6'd24; end
                default: begin
                    lo = 6'($urandom_range(5, 34));
                    if ($urandom_range(0, 5) == 0) hi = 6'($urandom_range(5, 34));
                    else hi = 6'($urandom_range(lo, 34));
                end
            endcase
            settle();
            set_lengths(lo, hi);
            mark = chars_sent;
            while (chars_sent < mark + PHASE_CHARS && chars_sent < RAND_CHARS) begin
                pick = $urandom_range(0, 19);
                if (pick < 13) build_iban(pick < 8, 1'b0);
                else if (pick < 17) build_iban(1'b1, 1'b1);
                else build_noise();
                send_text($urandom_range(0, 1), $urandom_range(0, 7) == 0, 1'b0, '0);
            end
        end

        settle();
        if (n_miss == 0)
            $display("iban_mod97_check_top regression: pass");
        else
            $display("iban_mod97_check_top regression: fail");
        $finish;
    end

endmodule
